### hdl/dgp2_pkg.sv
// Shared types, sizes, constant tables and helpers for the DG P2 advection step.
package dgp2_pkg;

  localparam int NUM_CELLS = 32;
  localparam int NUM_SLOTS = NUM_CELLS + 2;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int COEF_W    = 32;
  localparam int STEP_W    = 24;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd6711;

  // shared multiplier and accumulator
  localparam int OPA_W  = 36;
  localparam int OPB_W  = 33;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RND_SH = 30;

  // datapath value widths
  localparam int EDGE_W = 34;
  localparam int G_W    = 36;
  localparam int S_W    = 52;
  localparam int HALF_W = 31;
  localparam int HI_W   = S_W - HALF_W;
  localparam int LOP_W  = HALF_W + STEP_W + 1;
  localparam int R_W    = HI_W + STEP_W + 1;
  localparam int NEW_W  = R_W + 2;

  typedef struct packed {
    logic signed [COEF_W-1:0] coeff_zero;
    logic signed [COEF_W-1:0] coeff_one;
    logic signed [COEF_W-1:0] coeff_two;
    logic                     load_last;
  } in_word_t;

  typedef struct packed {
    logic [6:0]               cell_number;
    logic signed [COEF_W-1:0] new_coeff_zero;
    logic signed [COEF_W-1:0] new_coeff_one;
    logic signed [COEF_W-1:0] new_coeff_two;
    logic                     result_last;
  } out_word_t;

  typedef enum logic [2:0] {
    AS_COEF, AS_EDGE_CUR, AS_EDGE_PREV, AS_G, AS_HI, AS_LO
  } a_sel_t;

  typedef enum logic [2:0] {
    BK_RIGHT, BK_LEFT, BK_STIFF, BK_MASS, BK_STEP
  } b_kind_t;

  typedef enum logic [3:0] {
    ST_NONE, ST_EDGE, ST_G_SET, ST_G_SUB, ST_G_ADD, ST_S, ST_R_HI, ST_R_LO, ST_NEW
  } st_op_t;

  typedef struct packed {
    logic              load_in;
    logic              rd_en;
    logic              ld_coef;
    logic              mul_en;
    logic              mul_clr;
    a_sel_t            a_sel;
    b_kind_t           b_kind;
    logic [1:0]        row;
    logic [1:0]        col;
    st_op_t            st_op;
    logic              adv_edge;
    logic              emit;
    logic              keep_first;
    logic              ghost_lo;
    logic              ghost_hi;
    logic [SLOT_W-1:0] addr;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // edge basis values and stiffness, signed Q2.30
  function automatic logic signed [31:0] right_basis(input logic [1:0] k);
    case (k)
      2'd0:    return 32'sd95902752;
      2'd1:    return -32'sd357913941;
      2'd2:    return 32'sd1335753014;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [31:0] left_basis(input logic [1:0] k);
    case (k)
      2'd0:    return 32'sd1335753014;
      2'd1:    return -32'sd357913941;
      2'd2:    return 32'sd95902752;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [31:0] stiffness(input logic [1:0] j, input logic [1:0] k);
    case ({j, k})
      4'b0000: return -32'sd826566842;
      4'b0001: return -32'sd688805701;
      4'b0010: return 32'sd275522281;
      4'b0100: return 32'sd1102089122;
      4'b0101: return 32'sd0;
      4'b0110: return -32'sd1102089122;
      4'b1000: return -32'sd275522281;
      4'b1001: return 32'sd688805701;
      4'b1010: return 32'sd826566842;
      default: return '0;
    endcase
  endfunction

  // inverse mass in integers, scaled by NUM_CELLS/128
  function automatic logic signed [9:0] inv_mass(input logic [1:0] j, input logic [1:0] k);
    case ({j, k})
      4'b0000, 4'b1010: return 10'sd333;
      4'b0101:          return 10'sd144;
      4'b0010, 4'b1000: return 10'sd45;
      4'b0001, 4'b0100, 4'b0110, 4'b1001: return -10'sd36;
      default:          return '0;
    endcase
  endfunction

  // divide by 2^30, rounding half away from zero
  function automatic logic signed [ACC_W-1:0] round_shift(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] q;
    m = v[ACC_W-1] ? $unsigned(-v) : $unsigned(v);
    q = (m + (ACC_W'(1) << (RND_SH - 1))) >> RND_SH;
    return v[ACC_W-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [NEW_W-1:0] v);
    if (v > NEW_W'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < NEW_W'(-64'sd2147483648)) return 32'sh80000000;
    return v[COEF_W-1:0];
  endfunction

endpackage

### hdl/dgp2_ctrl.sv
// Sequencer: load handshake, per-cell step program and write-back order.
module dgp2_ctrl
  import dgp2_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     load_last,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_LOAD   = 8'b0000_0001,
    S_READ   = 8'b0000_0010,
    S_EDGE   = 8'b0000_0100,
    S_GRAD   = 8'b0000_1000,
    S_UPD    = 8'b0001_0000,
    S_OUT    = 8'b0010_0000,
    S_GHOST0 = 8'b0100_0000,
    S_GHOSTN = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [SLOT_W-1:0] cur_cell, cur_cell_next;
  logic [SLOT_W-1:0] load_cnt, load_cnt_next;
  logic [3:0]        sub, sub_next;
  logic [1:0]        row, row_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      cur_cell <= '0;
      load_cnt <= '0;
      sub      <= '0;
      row      <= '0;
    end else begin
      state    <= state_next;
      cur_cell <= cur_cell_next;
      load_cnt <= load_cnt_next;
      sub      <= sub_next;
      row      <= row_next;
    end
  end

  assign in_ready = (state == S_LOAD);

  always_comb begin
    cmd           = '0;
    cmd.row       = row;
    state_next    = state;
    cur_cell_next = cur_cell;
    load_cnt_next = load_cnt;
    sub_next      = sub + 4'd1;
    row_next      = row;
    unique case (state)
      S_LOAD: begin
        sub_next = '0;
        cmd.addr = load_cnt;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (load_last) begin
            load_cnt_next = '0;
            cur_cell_next = '0;
            state_next    = S_READ;
          end else begin
            load_cnt_next = (load_cnt == SLOT_W'(NUM_SLOTS - 1)) ? '0 : load_cnt + 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.addr   = cur_cell;
        sub_next   = '0;
        row_next   = '0;
        state_next = S_EDGE;
      end
      S_EDGE: begin
        case (sub)
          4'd0: cmd.ld_coef = 1'b1;
          4'd1, 4'd2, 4'd3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_clr = (sub == 4'd1);
            cmd.a_sel   = AS_COEF;
            cmd.b_kind  = BK_RIGHT;
            cmd.col     = 2'(sub - 4'd1);
          end
          4'd5: cmd.st_op = ST_EDGE;
          4'd6: begin
            sub_next = '0;
            if (cur_cell == '0) begin
              cmd.adv_edge  = 1'b1;
              cur_cell_next = cur_cell + 1'b1;
              state_next    = S_READ;
            end else begin
              state_next = S_GRAD;
            end
          end
          default: ;
        endcase
      end
      S_GRAD: begin
        case (sub)
          4'd0, 4'd1, 4'd2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_clr = (sub == 4'd0);
            cmd.a_sel   = AS_COEF;
            cmd.b_kind  = BK_STIFF;
            cmd.col     = sub[1:0];
          end
          4'd4: cmd.st_op = ST_G_SET;
          4'd5: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_clr = 1'b1;
            cmd.a_sel   = AS_EDGE_CUR;
            cmd.b_kind  = BK_RIGHT;
            cmd.col     = row;
          end
          4'd7: cmd.st_op = ST_G_SUB;
          4'd8: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_clr = 1'b1;
            cmd.a_sel   = AS_EDGE_PREV;
            cmd.b_kind  = BK_LEFT;
            cmd.col     = row;
          end
          4'd10: begin
            cmd.st_op = ST_G_ADD;
            sub_next  = '0;
            if (row == 2'd2) begin
              row_next   = '0;
              state_next = S_UPD;
            end else begin
              row_next = row + 2'd1;
            end
          end
          default: ;
        endcase
      end
      S_UPD: begin
        case (sub)
          4'd0, 4'd1, 4'd2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_clr = (sub == 4'd0);
            cmd.a_sel   = AS_G;
            cmd.b_kind  = BK_MASS;
            cmd.col     = sub[1:0];
          end
          4'd4: cmd.st_op = ST_S;
          4'd5: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_clr = 1'b1;
            cmd.a_sel   = AS_HI;
            cmd.b_kind  = BK_STEP;
          end
          4'd7: cmd.st_op = ST_R_HI;
          4'd8: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_clr = 1'b1;
            cmd.a_sel   = AS_LO;
            cmd.b_kind  = BK_STEP;
          end
          4'd10: cmd.st_op = ST_R_LO;
          4'd11: begin
            cmd.st_op = ST_NEW;
            sub_next  = '0;
            if (row == 2'd2) begin
              row_next   = '0;
              state_next = S_OUT;
            end else begin
              row_next = row + 2'd1;
            end
          end
          default: ;
        endcase
      end
      S_OUT: begin
        cmd.addr = cur_cell;
        sub_next = '0;
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.adv_edge   = 1'b1;
          cmd.keep_first = (cur_cell == SLOT_W'(1));
          if (cur_cell == SLOT_W'(NUM_CELLS)) begin
            state_next = S_GHOST0;
          end else begin
            cur_cell_next = cur_cell + 1'b1;
            state_next    = S_READ;
          end
        end
      end
      S_GHOST0: begin
        // left ghost takes the new last cell
        cmd.ghost_lo = 1'b1;
        cmd.addr     = '0;
        state_next   = S_GHOSTN;
      end
      S_GHOSTN: begin
        cmd.ghost_hi = 1'b1;
        cmd.addr     = SLOT_W'(NUM_SLOTS - 1);
        state_next   = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

### hdl/dgp2_dp.sv
// Datapath: cell store, shared multiply-accumulate, rounding, update and output register.
module dgp2_dp
  import dgp2_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  in_word_t          in_word,
  input  logic              cfg_write,
  input  logic [STEP_W-1:0] cfg_data,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word
);

  localparam logic signed [S_W-1:0] S_CELLS = S_W'(NUM_CELLS);

  logic [3*COEF_W-1:0]      mem [NUM_SLOTS];
  logic [3*COEF_W-1:0]      rdata;
  logic [3*COEF_W-1:0]      wdata;
  logic                     wr_en;

  logic [STEP_W-1:0]        time_step;
  logic signed [COEF_W-1:0] a [3];
  logic signed [COEF_W-1:0] nw [3];
  logic signed [COEF_W-1:0] first [3];
  logic signed [EDGE_W-1:0] e_cur, e_prev;
  logic signed [G_W-1:0]    g [3];
  logic signed [S_W-1:0]    s;
  logic [R_W-1:0]           r;

  logic signed [OPA_W-1:0]  opa;
  logic signed [OPB_W-1:0]  opb;
  logic signed [PROD_W-1:0] prod;
  logic                     mul_v, mul_c;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;

  logic [S_W-1:0]           s_mag;
  logic [HI_W-1:0]          s_hi;
  logic [HALF_W-1:0]        s_lo;
  logic [LOP_W-1:0]         lo_term;
  logic signed [NEW_W-1:0]  upd;

  always_ff @(posedge clk) begin
    if (rst) time_step <= STEP_RESET;
    else if (cfg_write) time_step <= cfg_data;
  end

  // cell store, three coefficients to a word
  always_comb begin
    wr_en = cmd.load_in | cmd.emit | cmd.ghost_lo | cmd.ghost_hi;
    if (cmd.load_in)       wdata = {in_word.coeff_zero, in_word.coeff_one, in_word.coeff_two};
    else if (cmd.ghost_hi) wdata = {first[0], first[1], first[2]};
    else                   wdata = {nw[0], nw[1], nw[2]};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[cmd.addr] <= wdata;
    if (cmd.rd_en) rdata <= mem[cmd.addr];
  end

  // operand selection
  always_comb begin
    case (cmd.a_sel)
      AS_COEF:      opa = OPA_W'(a[cmd.col]);
      AS_EDGE_CUR:  opa = OPA_W'(e_cur);
      AS_EDGE_PREV: opa = OPA_W'(e_prev);
      AS_G:         opa = g[cmd.col];
      AS_HI:        opa = OPA_W'($signed({1'b0, s_hi}));
      AS_LO:        opa = OPA_W'($signed({1'b0, s_lo}));
      default:      opa = '0;
    endcase
    case (cmd.b_kind)
      BK_RIGHT: opb = OPB_W'(right_basis(cmd.col));
      BK_LEFT:  opb = OPB_W'(left_basis(cmd.col));
      BK_STIFF: opb = OPB_W'(stiffness(cmd.row, cmd.col));
      BK_MASS:  opb = OPB_W'(inv_mass(cmd.row, cmd.col));
      BK_STEP:  opb = OPB_W'($signed({1'b0, time_step}));
      default:  opb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
      mul_c <= 1'b0;
    end else begin
      mul_v <= cmd.mul_en;
      mul_c <= cmd.mul_clr;
    end
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    if (mul_v) acc <= mul_c ? ACC_W'(prod) : acc + ACC_W'(prod);
  end

  always_comb begin
    rnd     = round_shift(acc);
    s_mag   = s[S_W-1] ? $unsigned(-s) : $unsigned(s);
    s_hi    = s_mag[S_W-1:HALF_W];
    s_lo    = s_mag[HALF_W-1:0];
    lo_term = (acc[LOP_W-1:0] + (LOP_W'(1) << (HALF_W - 1))) >> HALF_W;
    upd     = NEW_W'(a[cmd.row])
            + (s[S_W-1] ? -$signed({2'b00, r}) : $signed({2'b00, r}));
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_coef) begin
      a[0] <= rdata[3*COEF_W-1:2*COEF_W];
      a[1] <= rdata[2*COEF_W-1:COEF_W];
      a[2] <= rdata[COEF_W-1:0];
    end
    if (cmd.adv_edge) e_prev <= e_cur;
    case (cmd.st_op)
      ST_EDGE:  e_cur <= rnd[EDGE_W-1:0];
      ST_G_SET: g[cmd.row] <= rnd[G_W-1:0];
      ST_G_SUB: g[cmd.row] <= g[cmd.row] - rnd[G_W-1:0];
      ST_G_ADD: g[cmd.row] <= g[cmd.row] + rnd[G_W-1:0];
      ST_S:     s <= $signed(acc[S_W-1:0]) * S_CELLS;
      ST_R_HI:  r <= acc[R_W-1:0];
      ST_R_LO:  r <= r + lo_term[R_W-1:0];
      ST_NEW:   nw[cmd.row] <= sat32(upd);
      default:  ;
    endcase
    if (cmd.keep_first) begin
      first[0] <= nw[0];
      first[1] <= nw[1];
      first[2] <= nw[2];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word.cell_number    <= 7'(cmd.addr);
      out_word.new_coeff_zero <= nw[0];
      out_word.new_coeff_one  <= nw[1];
      out_word.new_coeff_two  <= nw[2];
      out_word.result_last    <= (cmd.addr == SLOT_W'(NUM_CELLS));
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

### hdl/dg_p2_advection_euler_step.sv
// Top level of the DG P2 advection Euler step: sequencer plus datapath.
//
//  port group   dir  word        notes
//  in_*         in   in_word_t   one cell of three coefficients per word
//  out_*        out  out_word_t  updated interior cell, 1..NUM_CELLS in order
//  cfg_*        in   time step   written when cfg_write is high
//
// Load: one word per cycle. After the word marked load_last the step runs:
// the left ghost's edge first, then each interior cell in turn through the
// one shared 36x33 multiplier, then a refresh of both ghost slots.
// A stalled output holds the sequencer at the end of the cell; no input is
// taken during the step. Synchronous reset clears control and sets time_step to 6711.
module dg_p2_advection_euler_step
  import dgp2_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word,
  input  logic              cfg_write,
  input  logic [STEP_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dgp2_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .load_last (in_word.load_last),
    .stat      (stat),
    .cmd       (cmd)
  );

  dgp2_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
